### design/edit_distance_align_traceback_core_defines.svh
// Assertion macros shared by the RTL.
`ifndef EDIT_DISTANCE_ALIGN_TRACEBACK_CORE_DEFINES_SVH
`define EDIT_DISTANCE_ALIGN_TRACEBACK_CORE_DEFINES_SVH

// Same-cycle implication, clocked on clk, off during reset.
`define EDAT_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("edat: same-cycle check failed");

// Next-cycle implication.
`define EDAT_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("edat: next-cycle check failed");

`endif

### design/edat_pkg.sv
package edat_pkg;

  localparam int SYM_W    = 9;
  localparam int MAT_W    = 12;
  localparam int CALC_W   = 14;
  localparam int OUTLEN_W = 9;

  localparam logic [SYM_W-1:0]    SYM_GAP      = 9'h1FF;
  localparam logic [OUTLEN_W-1:0] OUTLEN_RESET = 9'd256;

  localparam logic [CALC_W-1:0] SUB_PEN = 14'd2;
  localparam logic [CALC_W-1:0] DEL_PEN = 14'd1;
  localparam logic [CALC_W-1:0] INS_PEN = 14'd1;

  localparam logic REQ_LOAD     = 1'b0;
  localparam logic REQ_FETCH    = 1'b1;
  localparam logic KIND_SUMMARY = 1'b0;
  localparam logic KIND_PAIR    = 1'b1;

  typedef enum logic [1:0] {
    FLAG_NONE = 2'd0,
    FLAG_SUB  = 2'd1,
    FLAG_INS  = 2'd2,
    FLAG_DEL  = 2'd3
  } op_flag_t;

endpackage

### design/edit_distance_align_traceback_core.sv
// Channel | Handshake                 | Moves
// in      | in_valid / in_stall       | load of one symbol pair, or fetch of an aligned pair
// out     | out_valid / out_stall     | alignment summary or one aligned pair
// cfg     | cfg_valid / cfg_ready     | out_len (ready is always high)
//
// The final load runs the matrix fill (read and calc states per cell, one matrix read
// port), the traceback (up, left, diag, decide states per step), the leading-gap scan
// and visibility count (read and check states per entry), then the summary. A fetch
// has a read state, then its emit state. rst_n is synchronous, active low; no clearing
// pass after reset. A pending result waits in the output register while out_stall is high;
// the sequencer holds in its emit state until the register is free.
`include "edit_distance_align_traceback_core_defines.svh"

module edit_distance_align_traceback_core #(
  parameter int MAX_LEN = 256
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              in_req_type,
  input  logic signed [8:0] in_sym_a,
  input  logic signed [8:0] in_sym_b,
  input  logic              in_last_pair,
  output logic              out_valid,
  input  logic              out_stall,
  output logic              out_kind,
  output logic signed [8:0] out_a,
  output logic signed [8:0] out_b,
  output logic [8:0]        out_replace_count,
  output logic [8:0]        out_insert_count,
  output logic [8:0]        out_delete_count,
  output logic [9:0]        out_total_distance,
  output logic [9:0]        out_lead_skipped,
  output logic [8:0]        out_visible_a,
  output logic [8:0]        out_visible_b,
  output logic              out_pair_last,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [8:0]        cfg_data
);

  localparam int STRIDE = MAX_LEN + 1;
  localparam int LW     = $clog2(MAX_LEN + 1);              // i, j, n, load count
  localparam int SAW    = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
  localparam int AAW    = $clog2(2 * MAX_LEN);
  localparam int MAW    = $clog2(STRIDE * STRIDE);
  localparam int KW     = $clog2(2 * MAX_LEN + 1);
  localparam int NW     = (KW > 10) ? KW : 10;              // counts and pointers
  localparam int SW     = edat_pkg::SYM_W;
  localparam int MW     = edat_pkg::MAT_W;
  localparam int CW     = edat_pkg::CALC_W;

  typedef enum logic [3:0] {
    S_IDLE, S_FETCH_RD, S_FETCH_EMIT, S_FILL_RD, S_FILL_CALC,
    S_TB_UP, S_TB_LEFT, S_TB_DIAG, S_TB_DEC, S_SK_RD, S_SK_CHK,
    S_POST, S_VIS_RD, S_VIS_CHK, S_SUM_EMIT
  } state_t;

  state_t              state_r;
  logic [LW-1:0]       lc_r, n_r, i_r, j_r;
  logic [MAW-1:0]      rowbase_r;           // (i-1)*STRIDE
  logic [MW-1:0]       left_r, uprev_r;     // fill: M[i][j-1], M[i-1][j-1]; tb: left, up
  edat_pkg::op_flag_t  row_flag_r;
  logic [NW-1:0]       k_r, tn_r, rep_r, ins_r, del_r, skip_r;
  logic [NW-1:0]       kept_r, rp_r, vr_r, vis_a_r, vis_b_r;
  logic                hit_r;
  logic [8:0]          out_len_r;

  logic                out_valid_r, out_kind_r, out_pair_last_r;
  logic [SW-1:0]       out_a_r, out_b_r;
  logic [8:0]          out_rep_r, out_ins_r, out_del_r, out_vis_a_r, out_vis_b_r;
  logic [9:0]          out_tot_r, out_skip_r;

  // RAM signals
  logic                seq_we;
  logic [SAW-1:0]      seq_waddr, seqa_raddr, seqb_raddr;
  logic [SW-1:0]       seqa_rdata, seqb_rdata;
  logic                mat_we;
  logic [MAW-1:0]      mat_waddr, mat_raddr;
  logic [MW-1:0]       mat_wdata, mat_rdata;
  logic                cf_we;
  logic [1:0]          cf_rdata;
  logic                al_we;
  logic [AAW-1:0]      al_waddr, al_raddr;
  logic [SW-1:0]       al_a_wdata, al_b_wdata, al_a_rdata, al_b_rdata;

  logic [LW-1:0]       i_m1, j_m1, lc_inc;
  logic                accept, slot_free, emit, sym_ne;
  logic [MW-1:0]       up_f, tb_up_val, tb_left_val, tb_diag_val;
  edat_pkg::op_flag_t  cf_eff, fill_flag;
  logic [CW-1:0]       ci, cd, cs, fill_v;
  logic                both, take_diag, take_ins;
  logic [LW-1:0]       ni, nj;
  logic [NW-1:0]       k_m1, remain, vislim, out_len_ext;

  assign accept    = in_valid && (state_r == S_IDLE);
  assign in_stall  = (state_r != S_IDLE);
  assign cfg_ready = 1'b1;
  assign slot_free = !out_valid_r || !out_stall;
  assign emit      = slot_free && (state_r == S_FETCH_EMIT || state_r == S_SUM_EMIT);

  assign i_m1   = i_r - LW'(1);
  assign j_m1   = j_r - LW'(1);
  assign lc_inc = (lc_r < LW'(MAX_LEN)) ? lc_r + LW'(1) : lc_r;

  // symbol stores: written on load, read at (i-1, j-1) during fill and traceback
  assign seq_we     = accept && (in_req_type == edat_pkg::REQ_LOAD) && (lc_r < LW'(MAX_LEN));
  assign seq_waddr  = lc_r[SAW-1:0];
  assign seqa_raddr = i_m1[SAW-1:0];
  assign seqb_raddr = j_m1[SAW-1:0];
  assign sym_ne     = (seqa_rdata != seqb_rdata);

  // fill cell arithmetic; row 0 and column 0 are never stored, row 0 is substituted here
  assign up_f   = (i_r == LW'(1)) ? MW'(j_r) : mat_rdata;
  assign cf_eff = (i_r == LW'(1)) ? edat_pkg::FLAG_NONE : edat_pkg::op_flag_t'(cf_rdata);

  always_comb begin
    ci = CW'(up_f) + edat_pkg::INS_PEN + ((cf_eff != edat_pkg::FLAG_INS) ? CW'(1) : CW'(0));
    cd = CW'(left_r) + edat_pkg::DEL_PEN +
         ((row_flag_r != edat_pkg::FLAG_DEL) ? CW'(1) : CW'(0));
    cs = CW'(uprev_r) + (sym_ne ? edat_pkg::SUB_PEN : CW'(0));
    if (cs < ci && cs < cd) begin
      fill_v = cs; fill_flag = edat_pkg::FLAG_SUB;
    end else if (ci < cd) begin
      fill_v = ci; fill_flag = edat_pkg::FLAG_INS;
    end else begin
      fill_v = cd; fill_flag = edat_pkg::FLAG_DEL;
    end
  end

  assign mat_we    = (state_r == S_FILL_CALC);
  assign mat_waddr = rowbase_r + MAW'(STRIDE) + MAW'(j_r);
  assign mat_wdata = fill_v[MW-1:0];
  assign cf_we     = (state_r == S_FILL_CALC);

  always_comb begin
    case (state_r)
      S_TB_LEFT: mat_raddr = rowbase_r + MAW'(STRIDE) + MAW'(j_m1);
      S_TB_DIAG: mat_raddr = rowbase_r + MAW'(j_m1);
      default:   mat_raddr = rowbase_r + MAW'(j_r);
    endcase
  end

  // traceback neighbours with boundary substitution
  assign tb_up_val   = (i_r == LW'(1)) ? MW'(j_r) : mat_rdata;
  assign tb_left_val = (j_r == LW'(1)) ? MW'(i_r) : mat_rdata;
  assign tb_diag_val = (i_r == LW'(1)) ? MW'(j_m1) :
                       (j_r == LW'(1)) ? MW'(i_m1) : mat_rdata;

  assign both      = (i_r != '0) && (j_r != '0);
  assign take_diag = both && (tb_diag_val <= uprev_r) && (tb_diag_val <= left_r);
  assign take_ins  = both ? (!take_diag && (uprev_r < left_r)) : (i_r != '0);
  assign ni        = (take_diag || take_ins) ? i_m1 : i_r;
  assign nj        = take_ins ? j_r : j_m1;
  assign k_m1      = k_r - NW'(1);

  assign al_we      = (state_r == S_TB_DEC);
  assign al_waddr   = k_m1[AAW-1:0];
  assign al_a_wdata = (take_diag || take_ins) ? seqa_rdata : edat_pkg::SYM_GAP;
  assign al_b_wdata = take_ins ? edat_pkg::SYM_GAP : seqb_rdata;

  logic [NW-1:0] al_rsum;
  always_comb begin
    case (state_r)
      S_SK_RD, S_SK_CHK:      al_rsum = k_r;
      S_VIS_RD, S_VIS_CHK:    al_rsum = k_r + vr_r;
      default:                al_rsum = k_r + rp_r;
    endcase
  end
  assign al_raddr = al_rsum[AAW-1:0];

  assign out_len_ext = NW'(out_len_r);
  assign remain      = tn_r - k_r;
  assign vislim      = (kept_r < NW'(n_r)) ? kept_r : NW'(n_r);

  edat_ram #(.WIDTH(SW), .DEPTH(MAX_LEN)) u_seq_a (
    .clk, .we(seq_we), .waddr(seq_waddr), .wdata(in_sym_a),
    .raddr(seqa_raddr), .rdata(seqa_rdata));
  edat_ram #(.WIDTH(SW), .DEPTH(MAX_LEN)) u_seq_b (
    .clk, .we(seq_we), .waddr(seq_waddr), .wdata(in_sym_b),
    .raddr(seqb_raddr), .rdata(seqb_rdata));
  edat_ram #(.WIDTH(MW), .DEPTH(STRIDE * STRIDE)) u_matrix (
    .clk, .we(mat_we), .waddr(mat_waddr), .wdata(mat_wdata),
    .raddr(mat_raddr), .rdata(mat_rdata));
  // column flags: row 1 ignores the stored value, so no clearing is needed
  edat_ram #(.WIDTH(2), .DEPTH(STRIDE)) u_col_flag (
    .clk, .we(cf_we), .waddr(j_r), .wdata(fill_flag),
    .raddr(j_r), .rdata(cf_rdata));
  edat_ram #(.WIDTH(SW), .DEPTH(2 * MAX_LEN)) u_aligned_a (
    .clk, .we(al_we), .waddr(al_waddr), .wdata(al_a_wdata),
    .raddr(al_raddr), .rdata(al_a_rdata));
  edat_ram #(.WIDTH(SW), .DEPTH(2 * MAX_LEN)) u_aligned_b (
    .clk, .we(al_we), .waddr(al_waddr), .wdata(al_b_wdata),
    .raddr(al_raddr), .rdata(al_b_rdata));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      lc_r        <= '0;
      rp_r        <= '0;
      kept_r      <= '0;
      out_len_r   <= edat_pkg::OUTLEN_RESET;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid) begin
        out_len_r <= cfg_data;
      end
      if (out_valid_r && !out_stall && !emit) begin
        out_valid_r <= 1'b0;
      end

      case (state_r)
        S_IDLE: begin
          if (accept) begin
            if (in_req_type == edat_pkg::REQ_LOAD) begin
              if (in_last_pair) begin
                // start of alignment
                n_r        <= lc_inc;
                tn_r       <= NW'(lc_inc) << 1;
                lc_r       <= '0;
                rep_r      <= '0;
                ins_r      <= '0;
                del_r      <= '0;
                skip_r     <= '0;
                row_flag_r <= edat_pkg::FLAG_NONE;
                i_r        <= LW'(1);
                j_r        <= LW'(1);
                rowbase_r  <= '0;
                left_r     <= MW'(1);
                uprev_r    <= '0;
                if (lc_inc == '0) begin
                  k_r     <= '0;
                  state_r <= S_SK_RD;
                end else begin
                  k_r     <= NW'(lc_inc) << 1;
                  state_r <= S_FILL_RD;
                end
              end else begin
                lc_r <= lc_inc;
              end
            end else begin
              hit_r   <= (rp_r < kept_r);
              state_r <= S_FETCH_RD;
            end
          end
        end
        S_FETCH_RD: state_r <= S_FETCH_EMIT;
        S_FETCH_EMIT: begin
          if (slot_free) begin
            out_valid_r     <= 1'b1;
            out_kind_r      <= edat_pkg::KIND_PAIR;
            out_a_r         <= hit_r ? al_a_rdata : edat_pkg::SYM_GAP;
            out_b_r         <= hit_r ? al_b_rdata : edat_pkg::SYM_GAP;
            out_pair_last_r <= hit_r ? (rp_r + NW'(1) >= kept_r) : 1'b1;
            out_rep_r       <= '0;
            out_ins_r       <= '0;
            out_del_r       <= '0;
            out_tot_r       <= '0;
            out_skip_r      <= '0;
            out_vis_a_r     <= '0;
            out_vis_b_r     <= '0;
            if (hit_r) begin
              rp_r <= rp_r + NW'(1);
            end
            state_r <= S_IDLE;
          end
        end
        S_FILL_RD: state_r <= S_FILL_CALC;
        S_FILL_CALC: begin
          row_flag_r <= fill_flag;
          if (j_r == n_r) begin
            if (i_r == n_r) begin
              state_r <= S_TB_UP;       // i = j = n, rowbase already (n-1)*STRIDE
            end else begin
              i_r       <= i_r + LW'(1);
              j_r       <= LW'(1);
              rowbase_r <= rowbase_r + MAW'(STRIDE);
              left_r    <= MW'(i_r) + MW'(1);
              uprev_r   <= MW'(i_r);
              state_r   <= S_FILL_RD;
            end
          end else begin
            left_r  <= fill_v[MW-1:0];
            uprev_r <= up_f;
            j_r     <= j_r + LW'(1);
            state_r <= S_FILL_RD;
          end
        end
        // up address goes out here, left next, diagonal after; each read lands in the state after its address
        S_TB_UP: state_r <= S_TB_LEFT;
        S_TB_LEFT: begin
          uprev_r <= tb_up_val;
          state_r <= S_TB_DIAG;
        end
        S_TB_DIAG: begin
          left_r  <= tb_left_val;
          state_r <= S_TB_DEC;
        end
        S_TB_DEC: begin
          k_r <= k_m1;
          i_r <= ni;
          j_r <= nj;
          if (take_diag || take_ins) begin
            rowbase_r <= rowbase_r - MAW'(STRIDE);
          end
          if (take_diag) begin
            rep_r <= rep_r + (sym_ne ? NW'(1) : NW'(0));
          end else if (take_ins) begin
            ins_r <= ins_r + NW'(1);
          end else begin
            del_r <= del_r + NW'(1);
          end
          state_r <= (ni == '0 && nj == '0) ? S_SK_RD : S_TB_UP;
        end
        S_SK_RD: state_r <= (k_r >= tn_r) ? S_POST : S_SK_CHK;
        S_SK_CHK: begin
          if (al_a_rdata[SW-1] && al_b_rdata[SW-1]) begin
            k_r     <= k_r + NW'(1);
            skip_r  <= skip_r + NW'(1);
            state_r <= S_SK_RD;
          end else begin
            state_r <= S_POST;
          end
        end
        S_POST: begin
          kept_r  <= (out_len_ext < remain) ? out_len_ext : remain;
          rp_r    <= '0;
          vr_r    <= '0;
          vis_a_r <= '0;
          vis_b_r <= '0;
          state_r <= S_VIS_RD;
        end
        S_VIS_RD: state_r <= (vr_r >= vislim) ? S_SUM_EMIT : S_VIS_CHK;
        S_VIS_CHK: begin
          vis_a_r <= vis_a_r + (al_a_rdata[SW-1] ? NW'(0) : NW'(1));
          vis_b_r <= vis_b_r + (al_b_rdata[SW-1] ? NW'(0) : NW'(1));
          vr_r    <= vr_r + NW'(1);
          state_r <= S_VIS_RD;
        end
        S_SUM_EMIT: begin
          if (slot_free) begin
            out_valid_r     <= 1'b1;
            out_kind_r      <= edat_pkg::KIND_SUMMARY;
            out_a_r         <= '0;
            out_b_r         <= '0;
            out_pair_last_r <= 1'b0;
            out_rep_r       <= rep_r[8:0];
            out_ins_r       <= ins_r[8:0];
            out_del_r       <= del_r[8:0];
            out_tot_r       <= 10'(rep_r + ins_r + del_r);
            out_skip_r      <= skip_r[9:0];
            out_vis_a_r     <= vis_a_r[8:0];
            out_vis_b_r     <= vis_b_r[8:0];
            state_r         <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid          = out_valid_r;
  assign out_kind           = out_kind_r;
  assign out_a              = out_a_r;
  assign out_b              = out_b_r;
  assign out_replace_count  = out_rep_r;
  assign out_insert_count   = out_ins_r;
  assign out_delete_count   = out_del_r;
  assign out_total_distance = out_tot_r;
  assign out_lead_skipped   = out_skip_r;
  assign out_visible_a      = out_vis_a_r;
  assign out_visible_b      = out_vis_b_r;
  assign out_pair_last      = out_pair_last_r;

  // the read pointer never passes the kept count
  `EDAT_ASSERT_IMP(a_rp_le_kept, 1'b1, rp_r <= kept_r)
  // each traceback step consumes at least one of i, j, so k never falls below i + j
  `EDAT_ASSERT_IMP(a_tb_k_bound, state_r == S_TB_UP || state_r == S_TB_DEC, k_r >= NW'(i_r) + NW'(j_r))
  // the last cell of the fill hands over to the traceback
  `EDAT_ASSERT_NXT(a_fill_to_tb, state_r == S_FILL_CALC && i_r == n_r && j_r == n_r, state_r == S_TB_UP)

endmodule

### design/edat_ram.sv
module edat_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

### bench/edit_distance_align_traceback_core_tb.sv
module edit_distance_align_traceback_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SEQ_MAX   = 256;
  localparam int STRIDE    = SEQ_MAX + 1;
  // slowest step is the 256-pair fill plus traceback, stalls on top
  localparam int IDLE_LIMIT = 600000;
  localparam int RANDOM_ITEMS = 350;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0, in_stall;
  logic in_req_type = edat_pkg::REQ_LOAD;
  logic signed [8:0] in_sym_a = '0, in_sym_b = '0;
  logic in_last_pair = 1'b0;
  logic out_valid, out_stall = 1'b0, out_kind;
  logic signed [8:0] out_a, out_b;
  logic [8:0] out_replace_count, out_insert_count, out_delete_count;
  logic [9:0] out_total_distance, out_lead_skipped;
  logic [8:0] out_visible_a, out_visible_b;
  logic out_pair_last;
  logic cfg_valid = 1'b0, cfg_ready;
  logic [8:0] cfg_data = '0;

  always #5 clk = ~clk;

  edit_distance_align_traceback_core i_dut (.*);

  // one expected result transaction
  typedef struct packed {
    logic       kind;
    logic [8:0] a, b, rep, ins, del;
    logic [9:0] total, skipped;
    logic [8:0] vis_a, vis_b;
    logic       last;
  } align_result_t;

  align_result_t expected_results[$];

  // shadow state of the aligner
  logic [8:0]  sym_a_mem [SEQ_MAX];
  logic [8:0]  sym_b_mem [SEQ_MAX];
  int unsigned cost_mem [STRIDE*STRIDE];
  edat_pkg::op_flag_t col_flag [STRIDE];
  edat_pkg::op_flag_t row_flag;
  logic [8:0]  path_a [2*SEQ_MAX];
  logic [8:0]  path_b [2*SEQ_MAX];
  int unsigned loaded_pairs, fetch_ptr, kept_pairs, keep_len;

  int errors, results_seen, alignments, fetches, cfg_writes, max_len_seen;

  // Fill the cost matrix, trace back, drop leading double gaps, build the summary.
  function automatic align_result_t align_pairs(int unsigned n);
    align_result_t s;
    int unsigned i, j, k, r, ci, cd, cs, v, remain, lim;
    int unsigned rep, insn, deln, skip, va, vb;
    edat_pkg::op_flag_t f;
    s = '0; rep = 0; insn = 0; deln = 0; skip = 0; va = 0; vb = 0;
    foreach (col_flag[c]) col_flag[c] = edat_pkg::FLAG_NONE;
    row_flag = edat_pkg::FLAG_NONE;
    for (r = 0; r <= n; r++) begin
      cost_mem[r] = r;
      cost_mem[r*STRIDE] = r;
    end
    for (i = 1; i <= n; i++) begin
      for (j = 1; j <= n; j++) begin
        ci = cost_mem[(i-1)*STRIDE+j] + 1;
        cd = cost_mem[i*STRIDE+j-1] + 1;
        cs = cost_mem[(i-1)*STRIDE+j-1] + ((sym_a_mem[i-1] != sym_b_mem[j-1]) ? 2 : 0);
        // extra unit unless the same op was last chosen in this column / this row
        if (col_flag[j] != edat_pkg::FLAG_INS) ci++;
        if (row_flag != edat_pkg::FLAG_DEL) cd++;
        if (cs < ci && cs < cd) begin v = cs; f = edat_pkg::FLAG_SUB; end
        else if (ci < cd) begin v = ci; f = edat_pkg::FLAG_INS; end
        else begin v = cd; f = edat_pkg::FLAG_DEL; end
        cost_mem[i*STRIDE+j] = v & 12'hFFF;
        col_flag[j] = f;
        row_flag = f;
      end
    end
    k = 2*n; i = n; j = n;
    while (i > 0 && j > 0) begin
      ci = cost_mem[(i-1)*STRIDE+j];
      cd = cost_mem[i*STRIDE+j-1];
      cs = cost_mem[(i-1)*STRIDE+j-1];
      k--;
      if (cs <= ci && cs <= cd) begin
        i--; j--;
        path_a[k] = sym_a_mem[i]; path_b[k] = sym_b_mem[j];
        if (sym_a_mem[i] != sym_b_mem[j]) rep++;
      end else if (ci < cd) begin
        i--;
        path_a[k] = sym_a_mem[i]; path_b[k] = edat_pkg::SYM_GAP; insn++;
      end else begin
        j--;
        path_a[k] = edat_pkg::SYM_GAP; path_b[k] = sym_b_mem[j]; deln++;
      end
    end
    while (i > 0) begin
      k--; i--; path_a[k] = sym_a_mem[i]; path_b[k] = edat_pkg::SYM_GAP; insn++;
    end
    while (j > 0) begin
      k--; j--; path_a[k] = edat_pkg::SYM_GAP; path_b[k] = sym_b_mem[j]; deln++;
    end
    while (k < 2*n && path_a[k][8] && path_b[k][8]) begin
      k++; skip++;
    end
    remain = 2*n - k;
    for (r = 0; r < remain; r++) begin
      path_a[r] = path_a[r+k];
      path_b[r] = path_b[r+k];
    end
    kept_pairs = (keep_len < remain) ? keep_len : remain;
    fetch_ptr = 0;
    lim = (kept_pairs < n) ? kept_pairs : n;
    for (r = 0; r < lim; r++) begin
      if (!path_a[r][8]) va++;
      if (!path_b[r][8]) vb++;
    end
    s.kind = edat_pkg::KIND_SUMMARY;
    s.rep = 9'(rep); s.ins = 9'(insn); s.del = 9'(deln);
    s.total = 10'(rep + insn + deln);
    s.skipped = 10'(skip);
    s.vis_a = 9'(va); s.vis_b = 9'(vb);
    return s;
  endfunction

  // Apply one accepted input transaction to the shadow state.
  task automatic predict_item(logic req, logic [8:0] a, logic [8:0] b, logic last);
    align_result_t e;
    e = '0;
    if (req == edat_pkg::REQ_LOAD) begin
      if (loaded_pairs < SEQ_MAX) begin
        sym_a_mem[loaded_pairs] = a;
        sym_b_mem[loaded_pairs] = b;
        loaded_pairs++;
      end
      if (last) begin
        if (loaded_pairs > max_len_seen) max_len_seen = loaded_pairs;
        e = align_pairs(loaded_pairs);
        loaded_pairs = 0;
        alignments++;
        expected_results.push_back(e);
      end
    end else begin
      e.kind = edat_pkg::KIND_PAIR;
      fetches++;
      if (fetch_ptr < kept_pairs) begin
        e.a = path_a[fetch_ptr];
        e.b = path_b[fetch_ptr];
        e.last = (fetch_ptr + 1 >= kept_pairs);
        fetch_ptr++;
      end else begin
        e.a = edat_pkg::SYM_GAP; e.b = edat_pkg::SYM_GAP; e.last = 1'b1;
      end
      expected_results.push_back(e);
    end
  endtask

  // Sender: bursts of back-to-back transactions separated by random gaps.
  int burst_left;
  bit no_gaps;

  task automatic send_item(logic req, logic [8:0] a, logic [8:0] b, logic last);
    int gap;
    gap = 0;
    if (!no_gaps) begin
      if (burst_left == 0) begin
        gap = $urandom_range(0, 6);
        burst_left = $urandom_range(1, 20);
      end
      burst_left--;
    end
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_req_type  <= req;
    in_sym_a     <= a;
    in_sym_b     <= b;
    in_last_pair <= last;
    do @(negedge clk); while (in_stall);
    @(posedge clk);
    predict_item(req, a, b, last);
  endtask

  task automatic go_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
    // a plain load gives no result, so leave it time to settle
    repeat (10) @(posedge clk);
  endtask

  task automatic set_keep_len(logic [8:0] v);
    go_idle();
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(negedge clk); while (!cfg_ready);
    @(posedge clk);
    cfg_valid <= 1'b0;
    keep_len = v;
    cfg_writes++;
  endtask

  function automatic logic [8:0] rand_sym(int alphabet);
    int r;
    r = $urandom_range(0, 99);
    if (r < 12) return edat_pkg::SYM_GAP;
    if (alphabet > 0) return 9'($urandom_range(0, alphabet - 1));
    return 9'($urandom_range(0, 255));
  endfunction

  task automatic load_seq(int n, int alphabet, int lead_gaps);
    for (int p = 0; p < n; p++) begin
      if (p < lead_gaps)
        send_item(edat_pkg::REQ_LOAD, edat_pkg::SYM_GAP, edat_pkg::SYM_GAP, p == n - 1);
      else
        send_item(edat_pkg::REQ_LOAD, rand_sym(alphabet), rand_sym(alphabet), p == n - 1);
    end
  endtask

  task automatic fetch_n(int cnt);
    for (int p = 0; p < cnt; p++)
      send_item(edat_pkg::REQ_FETCH, 9'($urandom), 9'($urandom), 1'($urandom));
  endtask

  // --- tests ---

  task automatic test_fetch_before_alignment();
    fetch_n(2);
  endtask

  task automatic test_single_pairs();
    send_item(edat_pkg::REQ_LOAD, 9'd255, 9'd255, 1'b1);  // match, top symbol
    fetch_n(2);
    // whole path is double gaps
    send_item(edat_pkg::REQ_LOAD, edat_pkg::SYM_GAP, edat_pkg::SYM_GAP, 1'b1);
    fetch_n(1);
    send_item(edat_pkg::REQ_LOAD, 9'd0, edat_pkg::SYM_GAP, 1'b0);
    send_item(edat_pkg::REQ_LOAD, edat_pkg::SYM_GAP, 9'd255, 1'b1);
    fetch_n(5);                                  // runs past the kept pairs
  endtask

  task automatic test_keep_len_extremes();
    set_keep_len(9'd1);
    send_item(edat_pkg::REQ_LOAD, 9'd1, 9'd2, 1'b0);
    send_item(edat_pkg::REQ_LOAD, 9'd3, 9'd3, 1'b1);
    fetch_n(2);
    set_keep_len(9'd0);                          // nothing kept
    send_item(edat_pkg::REQ_LOAD, 9'd7, 9'd7, 1'b1);
    fetch_n(1);
    set_keep_len(9'd256);
  endtask

  task automatic test_full_length();
    // full 256 pairs, then a sequence overrunning the store
    load_seq(SEQ_MAX, 4, 3);
    fetch_n(6);
    load_seq(SEQ_MAX + 2, 0, 0);
    fetch_n(4);
  endtask

  task automatic test_random_sequences();
    int sent, n, alphabet, lead;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      if ($urandom_range(0, 9) == 0)
        set_keep_len(($urandom_range(0, 3) == 0) ? 9'd256 : 9'($urandom_range(1, 255)));
      no_gaps = ($urandom_range(0, 5) == 0);
      if ($urandom_range(0, 19) == 0) begin
        n = $urandom_range(1, 6);          // noise: a stray fetch, then a short sequence
        fetch_n(1);
        sent++;
      end else begin
        n = ($urandom_range(0, 39) == 0) ? $urandom_range(30, 64) : $urandom_range(1, 12);
      end
      alphabet = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 4);
      lead = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 3) : 0;
      load_seq(n, alphabet, lead);
      sent += n;
      n = $urandom_range(0, 2*n + 2);
      if (n > 30) n = 30;
      fetch_n(n);
      sent += n;
    end
  endtask

  // --- result checking, sampled mid-cycle ahead of the accepting edge ---
  always @(negedge clk) begin
    align_result_t got, e;
    if (rst_n && out_valid && !out_stall) begin
      got = {out_kind, out_a, out_b, out_replace_count, out_insert_count, out_delete_count,
             out_total_distance, out_lead_skipped, out_visible_a, out_visible_b,
             out_pair_last};
      results_seen++;
      if (expected_results.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result transaction %p", got);
      end else begin
        e = expected_results.pop_front();
        if (got != e) begin
          errors++;
          if (errors <= 10) $display("mismatch: expected %p got %p", e, got);
        end
      end
    end
  end

  // --- receiver stall pattern, in randomly chosen modes ---
  int unsigned cyc;
  int stall_mode;
  always @(posedge clk) begin
    cyc <= cyc + 1;
    if (cyc % 64 == 0) stall_mode <= $urandom_range(0, 3);
    case (stall_mode)
      0: out_stall <= 1'b0;
      1: out_stall <= 1'($urandom);
      2: out_stall <= (cyc % 4 == 0);
      default: out_stall <= (cyc % 32 < 12);
    endcase
  end

  // --- watchdog on cycles without any transaction ---
  int idle_cycles;
  always @(negedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles > IDLE_LIMIT) begin
      $display("edit_distance_align_traceback_core_tb: done, errors");
      $finish;
    end
  end

  initial begin
    keep_len = edat_pkg::OUTLEN_RESET;
    loaded_pairs = 0; fetch_ptr = 0; kept_pairs = 0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_fetch_before_alignment();
    test_single_pairs();
    test_keep_len_extremes();
    test_full_length();
    test_random_sequences();
    go_idle();
    repeat (50) @(posedge clk);
    if (expected_results.size() != 0) errors++;
    $display("covered %0d alignments (longest %0d pairs), %0d fetches, %0d out_len writes",
             alignments, max_len_seen, fetches, cfg_writes);
    $display("%0d result transactions checked, %0d failures", results_seen, errors);
    if (errors == 0) $display("edit_distance_align_traceback_core_tb: done, clean");
    else $display("edit_distance_align_traceback_core_tb: done, errors");
    $finish;
  end
endmodule

### edit_distance_align_traceback_core.f
+incdir+design
design/edat_pkg.sv
design/edat_ram.sv
design/edit_distance_align_traceback_core.sv
bench/edit_distance_align_traceback_core_tb.sv
